// ===== rtl/core/ucbt_pkg.sv =====
// Shared types, token codes and helpers for the UTF-8 word and CJK bigram tokenizer.
package ucbt_pkg;

    // Token kinds on the output beat
    localparam logic [1:0] KIND_CHAR     = 2'd0;
    localparam logic [1:0] KIND_WORD_END = 2'd1;
    localparam logic [1:0] KIND_BIGRAM   = 2'd2;
    localparam logic [1:0] KIND_EOT      = 2'd3;

    // Bit positions in a result mask, in emission order
    localparam int unsigned M_CHAR   = 0;
    localparam int unsigned M_WEND   = 1;
    localparam int unsigned M_BIGRAM = 2;
    localparam int unsigned M_EOT    = 3;

    // Decoder state carried from byte to byte
    typedef struct packed {
        logic [1:0]  bytes_still_expected;
        logic [20:0] partial_codepoint;
        logic        word_open;
        logic        previous_cjk_valid;
        logic [15:0] previous_cjk_codepoint;
    } t_state;

    // All results caused by one byte, packed as presence flags plus payload
    typedef struct packed {
        logic [3:0]  mask;
        logic [6:0]  word_char;
        logic [15:0] first_codepoint;
        logic [15:0] second_codepoint;
    } t_bundle;

    localparam t_state STATE_RESET = '{
        bytes_still_expected:   2'd0,
        partial_codepoint:      21'd0,
        word_open:              1'b0,
        previous_cjk_valid:     1'b0,
        previous_cjk_codepoint: 16'd0
    };

    // CJK unified and compatibility ideograph blocks that form bigram runs
    function automatic logic is_cjk(input logic [20:0] cp);
        logic r;
        r = ((cp >= 21'h03400) && (cp <= 21'h04DBF)) ||
            ((cp >= 21'h04E00) && (cp <= 21'h09FFF)) ||
            ((cp >= 21'h0F900) && (cp <= 21'h0FAFF));
        return r;
    endfunction

endpackage

// ===== rtl/core/ucbt_step.sv =====
// Per-byte decode: next tokenizer state and the bundle of results one byte causes.
module ucbt_step
    import ucbt_pkg::*;
(
    input  t_state      i_state,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output t_state      o_state,
    output t_bundle     o_bundle
);

    logic [20:0] w_cont_cp;
    logic        w_is_cont;
    logic        w_fresh;

    assign w_is_cont = (i_text_byte[7:6] == 2'b10);
    assign w_cont_cp = {i_state.partial_codepoint[14:0], i_text_byte[5:0]};
    // byte is taken as a fresh item unless it continues a pending sequence
    assign w_fresh   = (i_state.bytes_still_expected == 2'd0) || !w_is_cont;

    always_comb begin
        t_state  s;
        t_bundle b;
        s = i_state;
        b = '0;

        if (!w_fresh) begin
            // continuation byte: gather six more bits
            s.partial_codepoint    = w_cont_cp;
            s.bytes_still_expected = i_state.bytes_still_expected - 2'd1;
            if (i_state.bytes_still_expected == 2'd1) begin
                s.partial_codepoint = '0;
                if (s.word_open) begin
                    b.mask[M_WEND] = 1'b1;
                    s.word_open    = 1'b0;
                end
                if (is_cjk(w_cont_cp)) begin
                    if (s.previous_cjk_valid) begin
                        b.mask[M_BIGRAM]   = 1'b1;
                        b.first_codepoint  = s.previous_cjk_codepoint;
                        b.second_codepoint = w_cont_cp[15:0];
                    end
                    s.previous_cjk_codepoint = w_cont_cp[15:0];
                    s.previous_cjk_valid     = 1'b1;
                end else begin
                    s.previous_cjk_valid = 1'b0;
                end
            end
        end else begin
            // fresh byte: a pending sequence it breaks is dropped and ends the run
            if (i_state.bytes_still_expected != 2'd0) begin
                s.bytes_still_expected = 2'd0;
                s.partial_codepoint    = '0;
                s.previous_cjk_valid   = 1'b0;
            end
            if (!i_text_byte[7]) begin
                // ASCII
                s.previous_cjk_valid = 1'b0;
                if (i_text_byte inside {[8'h41:8'h5A]}) begin
                    b.mask[M_CHAR] = 1'b1;
                    b.word_char    = i_text_byte[6:0] + 7'h20;
                    s.word_open    = 1'b1;
                end else if (i_text_byte inside {[8'h61:8'h7A], [8'h30:8'h39]}) begin
                    b.mask[M_CHAR] = 1'b1;
                    b.word_char    = i_text_byte[6:0];
                    s.word_open    = 1'b1;
                end else if (s.word_open) begin
                    b.mask[M_WEND] = 1'b1;
                    s.word_open    = 1'b0;
                end
            end else begin
                // any non-ASCII byte ends the word
                if (s.word_open) begin
                    b.mask[M_WEND] = 1'b1;
                    s.word_open    = 1'b0;
                end
                if (i_text_byte inside {[8'hC2:8'hDF]}) begin
                    s.partial_codepoint    = {16'd0, i_text_byte[4:0]};
                    s.bytes_still_expected = 2'd1;
                end else if (i_text_byte inside {[8'hE0:8'hEF]}) begin
                    s.partial_codepoint    = {17'd0, i_text_byte[3:0]};
                    s.bytes_still_expected = 2'd2;
                end else if (i_text_byte inside {[8'hF0:8'hF4]}) begin
                    s.partial_codepoint    = {18'd0, i_text_byte[2:0]};
                    s.bytes_still_expected = 2'd3;
                end else begin
                    s.previous_cjk_valid = 1'b0;
                end
            end
        end

        // end of text: close the word, flag the end, back to reset state
        if (i_end_of_text) begin
            if (s.word_open) begin
                b.mask[M_WEND] = 1'b1;
            end
            b.mask[M_EOT] = 1'b1;
            s = STATE_RESET;
        end

        o_state  = s;
        o_bundle = b;
    end

endmodule

// ===== rtl/core/utf8_word_and_cjk_bigram_tokenizer.sv =====
// Top level: byte intake, tokenizer state and two-bundle result buffer.
// The results of a byte are registered into the result buffer and offered from its head.
// Throughput: one byte per cycle while each byte yields at most one result and i_stall
//   is low; a byte with several results emits them one by one on the single output port.
// A two-entry result buffer lets intake continue while a result waits to be taken.
// Reset (i_rst_n low, synchronous) empties the buffer and clears decoder state.
module utf8_word_and_cjk_bigram_tokenizer
    import ucbt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_token_kind,
    output logic [6:0]  o_word_char,
    output logic [15:0] o_first_codepoint,
    output logic [15:0] o_second_codepoint,
    output logic        o_run_last
);

    t_state     r_state, n_state, w_step_state;
    t_bundle    r_slot0, r_slot1, n_slot0, n_slot1, w_bundle;
    logic [1:0] r_cnt, n_cnt;
    logic [3:0] w_rest;
    logic       w_in_acc, w_out_acc, w_push, w_pop_bundle;

    ucbt_step u_step (
        .i_state       (r_state),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_state       (w_step_state),
        .o_bundle      (w_bundle)
    );

    // handshakes
    assign o_stall      = (r_cnt == 2'd2);
    assign w_in_acc     = i_valid && !o_stall;
    assign o_valid      = (r_cnt != 2'd0);
    assign w_out_acc    = o_valid && !i_stall;
    assign w_rest       = r_slot0.mask & (r_slot0.mask - 4'd1);
    assign w_pop_bundle = w_out_acc && (w_rest == 4'd0);
    assign w_push       = w_in_acc && (w_bundle.mask != 4'd0);

    // output beat: lowest pending result of the head bundle
    always_comb begin
        if (r_slot0.mask[M_CHAR]) begin
            o_token_kind = KIND_CHAR;
        end else if (r_slot0.mask[M_WEND]) begin
            o_token_kind = KIND_WORD_END;
        end else if (r_slot0.mask[M_BIGRAM]) begin
            o_token_kind = KIND_BIGRAM;
        end else begin
            o_token_kind = KIND_EOT;
        end
    end

    assign o_word_char        = (o_token_kind == KIND_CHAR) ? r_slot0.word_char : 7'd0;
    assign o_first_codepoint  = (o_token_kind == KIND_BIGRAM) ? r_slot0.first_codepoint : 16'd0;
    assign o_second_codepoint = (o_token_kind == KIND_BIGRAM) ? r_slot0.second_codepoint : 16'd0;
    assign o_run_last         = (w_rest == 4'd0);

    // buffer and state next values
    always_comb begin
        n_state = w_in_acc ? w_step_state : r_state;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        n_cnt   = r_cnt;
        if (w_out_acc && !w_pop_bundle) begin
            n_slot0.mask = w_rest;
        end
        if (w_pop_bundle) begin
            n_slot0 = r_slot1;
            n_cnt   = r_cnt - 2'd1;
        end
        if (w_push) begin
            if (n_cnt == 2'd0) begin
                n_slot0 = w_bundle;
            end else begin
                n_slot1 = w_bundle;
            end
            n_cnt = n_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // payload slots need no reset
    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

endmodule

// ===== rtl/core/ucbt_checker.sv =====
// Port-level checks for the tokenizer, bound to the top level.
module ucbt_checker
    import ucbt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_token_kind,
    input logic [6:0]  o_word_char,
    input logic [15:0] o_first_codepoint,
    input logic [15:0] o_second_codepoint,
    input logic        o_run_last
);

    // nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result offered after reset");

    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_token_kind) && $stable(o_word_char)
            && $stable(o_first_codepoint) && $stable(o_second_codepoint)
            && $stable(o_run_last))
        else $error("stalled beat changed");

    // end of text always closes the byte's results
    a_eot_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == KIND_EOT) |-> o_run_last)
        else $error("end of text not last result");

    // bigram members lie at or above 16'h3400, other kinds carry no codepoints
    a_bigram_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == KIND_BIGRAM)
            |-> (o_first_codepoint >= 16'h3400) && (o_second_codepoint >= 16'h3400))
        else $error("bigram codepoint out of range");

    a_no_stray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind != KIND_BIGRAM)
            |-> (o_first_codepoint == 16'd0) && (o_second_codepoint == 16'd0))
        else $error("codepoint on non-bigram beat");

endmodule

bind utf8_word_and_cjk_bigram_tokenizer ucbt_checker u_ucbt_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_token_kind       (o_token_kind),
    .o_word_char        (o_word_char),
    .o_first_codepoint  (o_first_codepoint),
    .o_second_codepoint (o_second_codepoint),
    .o_run_last         (o_run_last)
);
